>>> design/crf_pkg.sv
// Shared types and constants for the CMOS RTC register file.
package crf_pkg;

    // Store geometry
    localparam int STORE_DEPTH = 128;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // Bus actions
    localparam logic [2:0] ACT_TICK     = 3'd0;
    localparam logic [2:0] ACT_INDEX_WR = 3'd1;
    localparam logic [2:0] ACT_INDEX_RD = 3'd2;
    localparam logic [2:0] ACT_DATA_WR  = 3'd3;
    localparam logic [2:0] ACT_DATA_RD  = 3'd4;

    // Register indexes
    localparam logic [6:0] REG_SECOND   = 7'h00;
    localparam logic [6:0] REG_MINUTE   = 7'h02;
    localparam logic [6:0] REG_HOUR     = 7'h04;
    localparam logic [6:0] REG_WEEKDAY  = 7'h06;
    localparam logic [6:0] REG_MONTHDAY = 7'h07;
    localparam logic [6:0] REG_MONTH    = 7'h08;
    localparam logic [6:0] REG_YEAR     = 7'h09;
    localparam logic [6:0] REG_STATUS_A = 7'h0A;
    localparam logic [6:0] REG_STATUS_B = 7'h0B;
    localparam logic [6:0] REG_STATUS_C = 7'h0C;
    localparam logic [6:0] REG_STATUS_D = 7'h0D;
    localparam logic [6:0] REG_DIAG     = 7'h0E;
    localparam logic [6:0] REG_CENTURY  = 7'h32;

    // Reset contents of the status registers
    localparam logic [7:0] STATUS_A_RESET = 8'h26;
    localparam logic [7:0] STATUS_D_RESET = 8'h80;

    // Periodic flag / enable bit position in status B and C
    localparam int PERIODIC_POS = 6;

    // Reciprocal of 100 for the year split: q = (year * YEAR_RECIP) >> YEAR_SHIFT
    localparam int YEAR_RECIP = 5243;
    localparam int YEAR_SHIFT = 19;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  write_data;
        logic [5:0]  now_second;
        logic [5:0]  now_minute;
        logic [4:0]  now_hour;
        logic [2:0]  now_weekday;
        logic [4:0]  now_monthday;
        logic [3:0]  now_month;
        logic [13:0] now_year;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_pulse;
    } t_out_item;

    // Item held in the input register, with the year already split by 100
    typedef struct packed {
        t_in_item   item;
        logic [7:0] year_hi;
    } t_stage;

    // Store write request from the core
    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
    } t_store_wr;

    // Index to store slot, aliasing beyond the store depth
    function automatic logic [STORE_AW-1:0] slot_of(input logic [6:0] idx);
        logic [7:0] ext;
        ext = {1'b0, idx};
        if (ext >= 8'(STORE_DEPTH)) begin
            ext = ext - 8'(STORE_DEPTH);
        end
        return ext[STORE_AW-1:0];
    endfunction

endpackage

>>> design/crf_store.sv
// Byte store with per-entry valid bits, registered read and write bypass.
module crf_store (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [crf_pkg::STORE_AW-1:0] i_rd_addr,
    input  crf_pkg::t_store_wr           i_wr,
    output logic [7:0]                   o_rd_data
);
    import crf_pkg::*;

    logic [7:0]          r_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] r_valid;
    logic [7:0]          r_rd_data;
    logic [7:0]          r_byp_data;
    logic                r_byp;
    logic                r_rd_vld;
    logic [7:0]          r_rd_reset;
    logic                same_addr;

    // Value an entry holds after reset until written
    function automatic logic [7:0] reset_val(input logic [STORE_AW-1:0] a);
        logic [6:0] a7;
        a7 = 7'(a);
        if (a7 == REG_STATUS_A) return STATUS_A_RESET;
        if (a7 == REG_STATUS_D || a7 == REG_DIAG) return STATUS_D_RESET;
        return 8'h00;
    endfunction

    assign same_addr = i_wr.en && (i_wr.addr == i_rd_addr);

    // Memory array
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_byp_data <= i_wr.data;
            r_rd_reset <= reset_val(i_rd_addr);
        end
    end

    // Valid bits and read-side flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_byp    <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_byp    <= same_addr;
                r_rd_vld <= r_valid[i_rd_addr] || same_addr;
            end
        end
    end

    assign o_rd_data = !r_rd_vld ? r_rd_reset : (r_byp ? r_byp_data : r_rd_data);

    // A written entry reads back valid afterwards
    a_wr_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.en |=> r_valid[$past(i_wr.addr)])
        else $error("store entry not marked valid after write");

    // A bypassed read always counts as valid
    a_byp_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byp |-> r_rd_vld)
        else $error("bypass without valid read");

    // Read with same-address write selects the bypass path
    a_byp_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd_en && same_addr |=> r_byp && o_rd_data == $past(i_wr.data))
        else $error("write bypass missed");

endmodule

>>> design/crf_core.sv
// Item processing: RTC registers, periodic timer and result formation.
module crf_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  crf_pkg::t_stage              i_stage,
    input  logic [7:0]                   i_store_data,
    output crf_pkg::t_store_wr           o_store_wr,
    output logic [crf_pkg::STORE_AW-1:0] o_rd_addr,
    output crf_pkg::t_out_item           o_result
);
    import crf_pkg::*;

    logic [6:0]  r_sel, n_sel;
    logic        r_nmi, n_nmi;
    logic [15:0] r_cd, n_cd;
    logic        r_armed, n_armed;
    logic [15:0] r_interval, n_interval;
    logic [7:0]  r_stat_a, n_stat_a;
    logic [7:0]  r_stat_b, n_stat_b;
    logic [7:0]  r_stat_c, n_stat_c;

    t_in_item            it;
    logic [STORE_AW-1:0] cur_slot;
    logic [6:0]          slot7;
    logic [7:0]          stored;
    logic [13:0]         year_lo;
    logic                do_retime;
    logic [15:0]         new_iv;
    logic [7:0]          rd;
    logic                irq;

    // Binary to BCD of the value modulo 100
    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [7:0]  w;
        logic [15:0] t;
        logic [3:0]  tens;
        logic [7:0]  ones;
        w = v;
        if (w >= 8'd200) begin
            w = w - 8'd200;
        end else if (w >= 8'd100) begin
            w = w - 8'd100;
        end
        t    = 16'(w) * 16'd205;
        tens = t[14:11];
        ones = w - 8'(tens) * 8'd10;
        return {tens, ones[3:0]};
    endfunction

    assign it       = i_stage.item;
    assign cur_slot = slot_of(r_sel);
    assign slot7    = 7'(cur_slot);
    assign year_lo  = it.now_year - 14'(i_stage.year_hi) * 14'd100;

    // Current contents of the selected slot; status registers live in flops
    always_comb begin
        if (slot7 == REG_STATUS_A) begin
            stored = r_stat_a;
        end else if (slot7 == REG_STATUS_B) begin
            stored = r_stat_b;
        end else if (slot7 == REG_STATUS_C) begin
            stored = r_stat_c;
        end else begin
            stored = i_store_data;
        end
    end

    // Action decode and register updates
    always_comb begin
        n_sel      = r_sel;
        n_nmi      = r_nmi;
        n_cd       = r_cd;
        n_armed    = r_armed;
        n_interval = r_interval;
        n_stat_a   = r_stat_a;
        n_stat_b   = r_stat_b;
        n_stat_c   = r_stat_c;
        do_retime  = 1'b0;
        rd         = 8'h00;
        irq        = 1'b0;
        o_store_wr = '{en: 1'b0, addr: cur_slot, data: it.write_data};

        unique case (it.action)
            ACT_TICK: begin
                if (r_armed) begin
                    if (r_cd > 16'd1) begin
                        n_cd = r_cd - 16'd1;
                    end else begin
                        n_cd    = 16'd0;
                        irq     = r_stat_b[PERIODIC_POS] && !r_stat_c[PERIODIC_POS];
                        n_stat_c[PERIODIC_POS] = 1'b1;
                        n_armed = 1'b0;
                    end
                end
            end
            ACT_INDEX_WR: begin
                n_nmi = it.write_data[7];
                n_sel = it.write_data[6:0];
            end
            ACT_INDEX_RD: begin
                rd = {r_nmi, r_sel};
            end
            ACT_DATA_WR: begin
                o_store_wr.en = 1'b1;
                if (slot7 == REG_STATUS_A) n_stat_a = it.write_data;
                if (slot7 == REG_STATUS_B) n_stat_b = it.write_data;
                if (slot7 == REG_STATUS_C) n_stat_c = it.write_data;
                do_retime = (r_sel == REG_STATUS_A);
            end
            ACT_DATA_RD: begin
                unique case (r_sel)
                    REG_SECOND:   rd = to_bcd(8'(it.now_second));
                    REG_MINUTE:   rd = to_bcd(8'(it.now_minute));
                    REG_HOUR:     rd = to_bcd(8'(it.now_hour));
                    REG_WEEKDAY:  rd = to_bcd(8'(it.now_weekday) + 8'd1);
                    REG_MONTHDAY: rd = to_bcd(8'(it.now_monthday));
                    REG_MONTH:    rd = to_bcd(8'(it.now_month));
                    REG_YEAR:     rd = to_bcd(year_lo[7:0]);
                    REG_CENTURY:  rd = to_bcd(i_stage.year_hi);
                    REG_STATUS_A: begin
                        n_stat_a = r_stat_a ^ 8'h80;
                        rd       = n_stat_a;
                    end
                    REG_STATUS_C: begin
                        rd        = r_stat_c;
                        n_stat_c[PERIODIC_POS] = 1'b0;
                        do_retime = 1'b1;
                    end
                    default:      rd = stored;
                endcase
            end
            default: ;
        endcase

        // Periodic interval from status A: 1 << rate select, except the
        // slowest base at the top select, which runs every tick
        if (n_stat_a[5:4] == 2'd3 && n_stat_a[3:0] == 4'd15) begin
            new_iv = 16'd1;
        end else begin
            new_iv = 16'd1 << n_stat_a[3:0];
        end

        // Re-time the periodic timer
        if (do_retime) begin
            if (!n_stat_c[PERIODIC_POS]) begin
                if (!r_armed || r_interval != new_iv) begin
                    n_armed    = 1'b1;
                    n_interval = new_iv;
                    n_cd       = new_iv;
                end
            end else begin
                n_armed = 1'b0;
            end
        end

        o_store_wr.en = o_store_wr.en && i_fire;
    end

    assign o_result  = '{read_data: rd, irq_pulse: irq};
    assign o_rd_addr = slot_of(i_fire ? n_sel : r_sel);

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel      <= 7'd0;
            r_nmi      <= 1'b0;
            r_cd       <= 16'd64;
            r_armed    <= 1'b1;
            r_interval <= 16'd64;
            r_stat_a   <= STATUS_A_RESET;
            r_stat_b   <= 8'h00;
            r_stat_c   <= 8'h00;
        end else if (i_fire) begin
            r_sel      <= n_sel;
            r_nmi      <= n_nmi;
            r_cd       <= n_cd;
            r_armed    <= n_armed;
            r_interval <= n_interval;
            r_stat_a   <= n_stat_a;
            r_stat_b   <= n_stat_b;
            r_stat_c   <= n_stat_c;
        end
    end

    // An armed timer never sits at zero
    a_armed_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |-> r_cd != 16'd0)
        else $error("armed timer with zero count");

    // The interrupt only comes from a tick, with no read data
    a_irq_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_result.irq_pulse |-> it.action == ACT_TICK && rd == 8'h00)
        else $error("interrupt outside a tick");

    // Expiry sets the periodic flag and disarms the timer
    a_expiry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && it.action == ACT_TICK && r_armed && r_cd <= 16'd1
        |=> !r_armed && r_stat_c[PERIODIC_POS])
        else $error("timer expiry not recorded");

endmodule

>>> design/cmos_rtc_register_file.sv
// Top level of the CMOS RTC register file: handshakes, input and result registers.
//
// Usage:
//   Input channel (i_valid / o_ready / i_item) carries one bus action or one
//   clock tick per item. Output channel (o_valid / i_ready / o_item) returns
//   exactly one result per item: read data for index readback and data reads,
//   an interrupt pulse flag for ticks, zeros otherwise.
//   An item is held in an input register, processed by one pass of logic, and
//   lands in the result register, which drives o_valid. Throughput is one item
//   per cycle while the receiver takes results; the store is read on the accept
//   edge and written when the item completes, with a bypass for a write and
//   read of the same entry in adjacent items.
//   Reset (synchronous, active low) empties both registers and restores the
//   RTC state: index 0, status A = 0x26, status D and diagnostic = 0x80,
//   other entries zero, periodic timer armed with 64 ticks. Valid bits take
//   the store to its reset contents at once, with no clearing pass.
//   When the receiver stalls, the result register holds its item and one
//   more item may sit in the input register; o_ready then drops until the
//   result is taken.
module cmos_rtc_register_file (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  crf_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output crf_pkg::t_out_item o_item
);
    import crf_pkg::*;

    t_stage    r_stage;
    logic      r_in_valid;
    t_out_item r_out;
    logic      r_out_valid;

    logic                accept;
    logic                fire;
    logic [26:0]         year_prod;
    t_store_wr           store_wr;
    logic [STORE_AW-1:0] rd_addr;
    logic [7:0]          store_data;
    t_out_item           result;

    // Handshake control
    assign fire    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || fire;
    assign accept  = i_valid && o_ready;

    // Year split by 100 ahead of the input register
    assign year_prod = 27'(i_item.now_year) * 27'(YEAR_RECIP);

    // Input register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stage.item    <= i_item;
            r_stage.year_hi <= year_prod[YEAR_SHIFT+7:YEAR_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    crf_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .i_wr      (store_wr),
        .o_rd_data (store_data)
    );

    crf_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_stage      (r_stage),
        .i_store_data (store_data),
        .o_store_wr   (store_wr),
        .o_rd_addr    (rd_addr),
        .o_result     (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // A completed item always shows up in the result register
    a_fire_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("completed item lost");

    // Full pipe with a stalled receiver takes nothing new
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_ready |-> !o_ready)
        else $error("input taken while both registers full");

    // An empty input register never completes an item
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !fire)
        else $error("item completed from empty stage");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the CMOS RTC register file: directed and random bus traffic.

module tb;
    import crf_pkg::*;

    // Stimulus constants
    localparam int         RANDOM_ITEMS  = 1400;
    localparam int         LONG_HOLD     = 60;
    localparam int         TIMER_RESET   = 64;
    localparam logic [7:0] PERIODIC_MASK = 8'(1 << PERIODIC_POS);
    localparam logic [7:0] RATE_FASTEST  = 8'h20;  // base 32768, divider 0: one tick
    localparam logic [7:0] RATE_WRAP     = 8'h3F;  // base 16384, divider 15: rate underflows

    // Predictor of the register file and queue of the bus responses it owes
    class rtc_result_board;
        logic [7:0]  store [STORE_DEPTH];
        logic [6:0]  sel_index;
        logic        nmi_en;
        logic [15:0] countdown;
        logic [15:0] interval;
        logic        armed;
        t_out_item   owed_responses[$];
        int          mismatches;
        int          checked;

        function new();
            foreach (store[i]) store[i] = '0;
            store[REG_STATUS_A] = STATUS_A_RESET;
            store[REG_STATUS_D] = STATUS_D_RESET;
            store[REG_DIAG]     = STATUS_D_RESET;
            sel_index  = '0;
            nmi_en     = 1'b0;
            countdown  = 16'(TIMER_RESET);
            interval   = 16'(TIMER_RESET);
            armed      = 1'b1;
            mismatches = 0;
            checked    = 0;
        endfunction

        function logic [7:0] to_bcd(int unsigned v);
            int unsigned w;
            w = v % 100;
            return 8'(((w / 10) << 4) | (w % 10));
        endfunction

        // Re-time the periodic timer from status A
        function void retime_timer();
            logic [7:0]  a;
            int unsigned base;
            int unsigned rate;
            logic [15:0] ivl;
            a = store[REG_STATUS_A];
            case (a[5:4])
                2'd0:    base = 4194304;
                2'd1:    base = 1048576;
                2'd2:    base = 32768;
                default: base = 16384;
            endcase
            rate = base >> a[3:0];
            ivl  = (rate > 0) ? 16'(base / rate) : 16'd1;
            if (!store[REG_STATUS_C][PERIODIC_POS]) begin
                if (!armed) begin
                    armed     = 1'b1;
                    interval  = ivl;
                    countdown = ivl;
                end else if (interval != ivl) begin
                    interval  = ivl;
                    countdown = ivl;
                end
            end else if (armed) begin
                armed = 1'b0;
            end
        endfunction

        function t_out_item predict_response(t_in_item it);
            t_out_item   resp;
            int unsigned yr;
            resp = '0;
            yr   = it.now_year;
            case (it.action)
                ACT_TICK: begin
                    if (armed) begin
                        if (countdown > 16'd1) begin
                            countdown = countdown - 16'd1;
                        end else begin
                            countdown = '0;
                            if (store[REG_STATUS_B][PERIODIC_POS] &&
                                !store[REG_STATUS_C][PERIODIC_POS]) begin
                                resp.irq_pulse = 1'b1;
                            end
                            store[REG_STATUS_C][PERIODIC_POS] = 1'b1;
                            armed = 1'b0;
                        end
                    end
                end
                ACT_INDEX_WR: begin
                    nmi_en    = it.write_data[7];
                    sel_index = it.write_data[6:0];
                end
                ACT_INDEX_RD: begin
                    resp.read_data = {nmi_en, sel_index};
                end
                ACT_DATA_WR: begin
                    store[sel_index % STORE_DEPTH] = it.write_data;
                    if (sel_index == REG_STATUS_A) retime_timer();
                end
                ACT_DATA_RD: begin
                    case (sel_index)
                        REG_SECOND:   resp.read_data = to_bcd(it.now_second);
                        REG_MINUTE:   resp.read_data = to_bcd(it.now_minute);
                        REG_HOUR:     resp.read_data = to_bcd(it.now_hour);
                        REG_WEEKDAY:  resp.read_data = to_bcd(it.now_weekday + 1);
                        REG_MONTHDAY: resp.read_data = to_bcd(it.now_monthday);
                        REG_MONTH:    resp.read_data = to_bcd(it.now_month);
                        REG_YEAR:     resp.read_data = to_bcd(yr % 100);
                        REG_CENTURY:  resp.read_data = to_bcd(yr / 100);
                        REG_STATUS_A: begin
                            // update-in-progress bit flips on every read
                            store[REG_STATUS_A][7] = ~store[REG_STATUS_A][7];
                            resp.read_data = store[REG_STATUS_A];
                        end
                        REG_STATUS_C: begin
                            // read returns the flags, then clears the periodic one
                            resp.read_data = store[REG_STATUS_C];
                            store[REG_STATUS_C][PERIODIC_POS] = 1'b0;
                            retime_timer();
                        end
                        default: resp.read_data = store[sel_index % STORE_DEPTH];
                    endcase
                end
                default: ;  // undefined action: ignored
            endcase
            return resp;
        endfunction

        function void note_item(t_in_item it);
            owed_responses.push_back(predict_response(it));
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (owed_responses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: result with nothing pending: read_data=%h irq_pulse=%b",
                             got.read_data, got.irq_pulse);
                end
                return;
            end
            want = owed_responses.pop_front();
            if (got.read_data !== want.read_data || got.irq_pulse !== want.irq_pulse) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: result %0d: read_data exp %h got %h, irq_pulse exp %b got %b",
                             checked, want.read_data, got.read_data,
                             want.irq_pulse, got.irq_pulse);
                end
            end
            checked++;
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_item;

    rtc_result_board board = new();
    int items_sent;
    int burst_left;
    bit hold_request;
    bit rx_holding;

    cmos_rtc_register_file u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Watch both channels: check results, then predict the accepted item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) board.check_result(o_item);
            if (i_valid && o_ready) board.note_item(i_item);
        end
    end

    // Random time fields, mostly in range, sometimes any bit pattern
    function automatic t_in_item random_time();
        t_in_item it;
        it = '0;
        if ($urandom_range(0, 7) == 0) begin
            it.now_second   = 6'($urandom);
            it.now_minute   = 6'($urandom);
            it.now_hour     = 5'($urandom);
            it.now_weekday  = 3'($urandom);
            it.now_monthday = 5'($urandom);
            it.now_month    = 4'($urandom);
            it.now_year     = 14'($urandom);
        end else begin
            it.now_second   = 6'($urandom_range(0, 59));
            it.now_minute   = 6'($urandom_range(0, 59));
            it.now_hour     = 5'($urandom_range(0, 23));
            it.now_weekday  = 3'($urandom_range(0, 6));
            it.now_monthday = 5'($urandom_range(1, 31));
            it.now_month    = 4'($urandom_range(1, 12));
            it.now_year     = 14'($urandom_range(0, 9999));
        end
        return it;
    endfunction

    // Register index, biased toward the ones with special behavior
    function automatic logic [6:0] pick_index();
        case ($urandom_range(0, 15))
            0:       return REG_SECOND;
            1:       return REG_MINUTE;
            2:       return REG_HOUR;
            3:       return REG_WEEKDAY;
            4:       return REG_MONTHDAY;
            5:       return REG_MONTH;
            6:       return REG_YEAR;
            7:       return REG_CENTURY;
            8:       return REG_STATUS_A;
            9:       return REG_STATUS_B;
            10:      return REG_STATUS_C;
            11:      return REG_STATUS_D;
            12:      return REG_DIAG;
            default: return 7'($urandom);
        endcase
    endfunction

    // Offer one item, hold it until accepted, then maybe open a gap
    task automatic send_item(input t_in_item it);
        i_item  <= it;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        if (it.action <= ACT_DATA_RD) items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else if (!rx_holding) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    task automatic send_op(input logic [2:0] act, input logic [7:0] wd, input t_in_item base);
        t_in_item it;
        it            = base;
        it.action     = act;
        it.write_data = wd;
        send_item(it);
    endtask

    // Receiver: segments of differing stall density, plus long holds on request
    initial begin
        int mode;
        int len;
        i_ready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(5, 60);
            repeat (len) begin
                case (mode)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= 1'($urandom);
                    2:       i_ready <= ($urandom_range(0, 3) != 0);
                    default: i_ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge i_clk);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                rx_holding   = 1'b1;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                rx_holding = 1'b0;
            end
        end
    end

    // Main stimulus
    initial begin
        t_in_item   tmax;
        t_in_item   tmin;
        t_in_item   tones;
        int         kind;
        logic [6:0] idx;
        logic [7:0] wd;
        bit         second_hold;

        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_item  <= '0;
        items_sent   = 0;
        burst_left   = 0;
        hold_request = 1'b0;
        rx_holding   = 1'b0;
        second_hold  = 1'b0;

        tmin  = '0;
        tmin.now_monthday = 5'd1;
        tmin.now_month    = 4'd1;
        tmax  = '0;
        tmax.now_second   = 6'd59;
        tmax.now_minute   = 6'd59;
        tmax.now_hour     = 5'd23;
        tmax.now_weekday  = 3'd6;
        tmax.now_monthday = 5'd31;
        tmax.now_month    = 4'd12;
        tmax.now_year     = 14'd9999;
        tones = '1;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset index, every time register at its extremes
        send_op(ACT_INDEX_RD, 8'h00, tmin);
        send_op(ACT_INDEX_WR, {1'b0, REG_SECOND}, tmax);
        send_op(ACT_DATA_RD, 8'h00, tmax);
        send_op(ACT_INDEX_WR, {1'b1, REG_MINUTE}, tmin);
        send_op(ACT_DATA_RD, 8'h00, tmin);
        send_op(ACT_INDEX_WR, {1'b0, REG_HOUR}, tmax);
        send_op(ACT_DATA_RD, 8'hFF, tmax);
        send_op(ACT_INDEX_WR, {1'b0, REG_WEEKDAY}, tmax);
        send_op(ACT_DATA_RD, 8'h00, tmax);
        send_op(ACT_INDEX_WR, {1'b0, REG_MONTHDAY}, tmin);
        send_op(ACT_DATA_RD, 8'h00, tones);
        send_op(ACT_INDEX_WR, {1'b0, REG_MONTH}, tmax);
        send_op(ACT_DATA_RD, 8'h00, tmax);
        send_op(ACT_INDEX_WR, {1'b0, REG_YEAR}, tmax);
        send_op(ACT_DATA_RD, 8'h00, tmax);
        send_op(ACT_INDEX_WR, {1'b0, REG_CENTURY}, tones);
        send_op(ACT_DATA_RD, 8'h00, tones);

        // Directed: status A toggle, periodic interrupt, flag clear and re-arm
        send_op(ACT_INDEX_WR, {1'b0, REG_STATUS_A}, tmin);
        send_op(ACT_DATA_RD, 8'h00, tmin);
        send_op(ACT_INDEX_WR, {1'b0, REG_STATUS_B}, tmin);
        send_op(ACT_DATA_WR, PERIODIC_MASK, tmin);
        send_op(ACT_INDEX_WR, {1'b0, REG_STATUS_A}, tmin);
        send_op(ACT_DATA_WR, RATE_FASTEST, tmin);
        send_op(ACT_TICK, 8'h00, tmin);
        send_op(ACT_INDEX_WR, {1'b0, REG_STATUS_C}, tmin);
        send_op(ACT_DATA_RD, 8'h00, tmin);
        send_op(ACT_TICK, 8'h00, tmin);
        // underflowing rate while the flag is set, then readback with NMI bit
        send_op(ACT_INDEX_WR, {1'b1, REG_STATUS_A}, tmin);
        send_op(ACT_DATA_WR, RATE_WRAP, tmin);
        send_op(ACT_INDEX_RD, 8'h00, tmin);

        // Random traffic, mostly well-formed index/data sequences
        hold_request = 1'b1;
        items_sent   = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (!second_hold && items_sent >= RANDOM_ITEMS / 2) begin
                hold_request = 1'b1;
                second_hold  = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                repeat ($urandom_range(1, 20)) send_op(ACT_TICK, 8'($urandom), random_time());
            end else if (kind < 55) begin
                send_op(ACT_INDEX_WR, {1'($urandom), pick_index()}, random_time());
                repeat ($urandom_range(1, 3)) send_op(ACT_DATA_RD, 8'($urandom), random_time());
            end else if (kind < 72) begin
                case ($urandom_range(0, 3))
                    0:       idx = REG_STATUS_A;
                    1:       idx = REG_STATUS_B;
                    default: idx = pick_index();
                endcase
                wd = 8'($urandom);
                // short periods keep interrupts coming
                if (idx == REG_STATUS_A && $urandom_range(0, 3) != 0) begin
                    wd[3:0] = 4'($urandom_range(0, 5));
                end
                if (idx == REG_STATUS_B && $urandom_range(0, 3) != 0) begin
                    wd[PERIODIC_POS] = 1'b1;
                end
                send_op(ACT_INDEX_WR, {1'($urandom), idx}, random_time());
                send_op(ACT_DATA_WR, wd, random_time());
            end else if (kind < 82) begin
                send_op(ACT_INDEX_WR, {1'($urandom), REG_STATUS_C}, random_time());
                send_op(ACT_DATA_RD, 8'($urandom), random_time());
            end else if (kind < 90) begin
                send_op(ACT_INDEX_RD, 8'($urandom), random_time());
            end else if (kind < 96) begin
                send_op($urandom_range(0, 1) ? ACT_DATA_WR : ACT_DATA_RD, 8'($urandom),
                        random_time());
            end else begin
                // noise, undefined actions included
                send_op(3'($urandom), 8'($urandom), random_time());
            end
        end
        i_valid <= 1'b0;

        // Drain, then let the pipeline settle
        while (board.owed_responses.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.mismatches == 0 && board.owed_responses.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
design/crf_pkg.sv
design/crf_store.sv
design/crf_core.sv
design/cmos_rtc_register_file.sv
tb/tb.sv
